[rtl/phgd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Package for the peak-hold meter: field widths, register indexes and reset values,
// controller states and the command/status words between controller and datapath.
// No dependencies.
package phgd_pkg;

  localparam int LEVEL_W    = 16;
  localparam int FLEN_W     = 13;
  localparam int BIN_W      = 12;
  localparam int BAR_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [BIN_W-1:0] BIN_COUNT_MAX = 12'd4095;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_ACCEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIS_THRESH   = 2'd2;

  localparam logic [FLEN_W-1:0]  FRAME_LENGTH_RST = 13'd1024;
  localparam logic [LEVEL_W-1:0] FALL_ACCEL_RST   = 16'd33;
  localparam logic [LEVEL_W-1:0] VIS_THRESH_RST   = 16'd328;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_UPDATE,
    ST_NEXT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic take;    // latch input word
    logic rd;      // read bar state at next_bar
    logic upd;     // apply decay, write back, load result, advance next_bar
    logic mark;    // record whether the loaded result ends the run
    logic finish;  // advance or clear the bin counter
  } cmd_t;

  typedef struct packed {
    logic more;    // bar at next_bar is served by the current bin
    logic last;    // loaded result is the last one for this bin
  } status_t;

endpackage
`default_nettype wire

[rtl/phgd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one magnitude bin per word with its frame-end mark.
// Depends on phgd_pkg.
interface phgd_in_if;
  import phgd_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] magnitude;
  logic               frame_end;
  modport source (output valid, magnitude, frame_end, input ready);
  modport sink   (input valid, magnitude, frame_end, output ready);
endinterface
`default_nettype wire

[rtl/phgd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Output channel: one updated bar per word.
// Depends on phgd_pkg.
interface phgd_out_if;
  import phgd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BAR_IDX_W-1:0] bar_index;
  logic [LEVEL_W-1:0]   peak_level;
  logic                 peak_visible;
  logic                 last_of_run;
  modport source (output valid, bar_index, peak_level, peak_visible, last_of_run,
                  input ready);
  modport sink   (input valid, bar_index, peak_level, peak_visible, last_of_run,
                  output ready);
endinterface
`default_nettype wire

[rtl/phgd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for the peak-hold meter: walks the bars served by one bin.
// Depends on phgd_pkg.
module phgd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  phgd_pkg::status_t status,
  output phgd_pkg::cmd_t    cmd
);
  import phgd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = status.more ? ST_READ : ST_IDLE;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_NEXT;
      ST_NEXT:   state_next = ST_SEND;
      ST_SEND: begin
        if (out_ready) state_next = status.last ? ST_IDLE : ST_READ;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_CHECK:  cmd.finish = !status.more;
      ST_READ:   cmd.rd = 1'b1;
      ST_UPDATE: cmd.upd = 1'b1;
      ST_NEXT:   cmd.mark = 1'b1;
      ST_SEND: begin
        out_valid  = 1'b1;
        cmd.finish = out_ready && status.last;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/phgd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Datapath for the peak-hold meter: config registers, bin/bar counters,
// bar state memory with valid bits, decay arithmetic and the result register.
// Depends on phgd_pkg.
module phgd_dp #(
  parameter int NUM_BARS  = 64,
  parameter int MAX_FRAME = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [phgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phgd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  phgd_pkg::cmd_t                       cmd,
  output phgd_pkg::status_t                    status,
  input  logic [phgd_pkg::LEVEL_W-1:0]         magnitude,
  input  logic                                 frame_end,
  output logic [phgd_pkg::BAR_IDX_W-1:0]       bar_index,
  output logic [phgd_pkg::LEVEL_W-1:0]         peak_level,
  output logic                                 peak_visible,
  output logic                                 last_of_run
);
  import phgd_pkg::*;

  localparam int BAR_W  = $clog2(NUM_BARS + 1);
  localparam int IDX_W  = $clog2(NUM_BARS);
  localparam int PROD_W = BAR_W + FLEN_W;
  localparam int LIM_W  = BIN_W + BAR_W;
  localparam int CMP_W  = (PROD_W > LIM_W) ? PROD_W : LIM_W;

  logic [FLEN_W-1:0]  frame_length;
  logic [LEVEL_W-1:0] fall_accel;
  logic [LEVEL_W-1:0] vis_thresh;

  logic [BIN_W-1:0]   bin_count;
  logic [BAR_W-1:0]   next_bar;
  logic [LEVEL_W-1:0] mag_q;
  logic               fend_q;
  logic               last_q;

  logic [2*LEVEL_W-1:0] bar_mem [NUM_BARS];
  logic [NUM_BARS-1:0]  bar_vld;
  logic [2*LEVEL_W-1:0] rd_data;
  logic                 rd_vld;

  logic [FLEN_W-1:0]  eff_len;
  logic [PROD_W-1:0]  prod;
  logic [LIM_W-1:0]   lim;
  logic [IDX_W-1:0]   idx;
  logic [LEVEL_W-1:0] cur_peak, cur_speed, new_peak, new_speed;
  logic [LEVEL_W:0]   speed_sum;

  always_comb begin
    eff_len = frame_length;
    if (frame_length == '0) begin
      eff_len = FLEN_W'(1);
    end else if (32'(frame_length) > MAX_FRAME) begin
      eff_len = FLEN_W'(MAX_FRAME);
    end
  end

  // bar b is served once floor(b*len/N) <= bin_count, i.e. b*len <= bin_count*N + N-1
  assign prod = PROD_W'(next_bar) * PROD_W'(eff_len);
  assign lim  = LIM_W'(bin_count) * LIM_W'(NUM_BARS) + LIM_W'(NUM_BARS - 1);
  assign status.more = (32'(next_bar) < NUM_BARS) && (CMP_W'(prod) <= CMP_W'(lim));
  assign status.last = last_q;

  assign idx = next_bar[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_LENGTH_RST;
      fall_accel   <= FALL_ACCEL_RST;
      vis_thresh   <= VIS_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH: frame_length <= cfg_wdata[FLEN_W-1:0];
        CFG_FALL_ACCEL:   fall_accel   <= cfg_wdata[LEVEL_W-1:0];
        CFG_VIS_THRESH:   vis_thresh   <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // decay step on the state read back from memory
  always_comb begin
    cur_peak  = rd_vld ? rd_data[2*LEVEL_W-1:LEVEL_W] : '0;
    cur_speed = rd_vld ? rd_data[LEVEL_W-1:0] : '0;
    speed_sum = {1'b0, cur_speed} + {1'b0, fall_accel};
    if (mag_q > cur_peak) begin
      new_peak  = mag_q;
      new_speed = '0;
    end else begin
      new_speed = speed_sum[LEVEL_W] ? '1 : speed_sum[LEVEL_W-1:0];
      new_peak  = (cur_peak > new_speed) ? cur_peak - new_speed : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= bar_mem[idx];
    end
    if (cmd.upd) begin
      bar_mem[idx] <= {new_peak, new_speed};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_vld   <= '0;
      rd_vld    <= 1'b0;
      bin_count <= '0;
      next_bar  <= '0;
      last_q    <= 1'b0;
    end else begin
      if (cmd.rd) rd_vld <= bar_vld[idx];
      if (cmd.upd) begin
        bar_vld[idx] <= 1'b1;
        next_bar     <= next_bar + BAR_W'(1);
      end
      if (cmd.mark) last_q <= !status.more;
      if (cmd.finish) begin
        if (fend_q) begin
          bin_count <= '0;
          next_bar  <= '0;
        end else if (bin_count < BIN_COUNT_MAX) begin
          bin_count <= bin_count + BIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mag_q  <= magnitude;
      fend_q <= frame_end;
    end
    if (cmd.upd) begin
      bar_index    <= BAR_IDX_W'(next_bar);
      peak_level   <= new_peak;
      peak_visible <= new_peak > vis_thresh;
    end
  end

  assign last_of_run = last_q;

endmodule
`default_nettype wire

[rtl/peak_hold_gravity_decay.sv]
`timescale 1ns / 1ps
`default_nettype none
// Peak-hold spectrum meter with accelerating decay.
// in_ch takes one magnitude bin per word (unsigned Q1.15) with frame_end on
// the last bin of a frame. Each bin updates every bar whose source bin
// floor(bar*frame_length/NUM_BARS) it has reached; out_ch gives one word per
// updated bar in rising bar order, last_of_run set on the final one of a bin.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do
// so only while idle, as the block does not enforce it. A bin serving no bar
// is only taken and checked. Each served bar takes a memory read, the decay
// update, the end-of-run check and showing the result word, plus any output
// stall. The bar state lives in one memory port, so bars are done one at a
// time, and the next bin is taken once the last result word has been
// accepted. A stalled receiver holds the result word and the block waits.
// Reset (rst, synchronous) restores the register defaults and clears the
// counters; all bar peaks and speeds read as zero at once through per-bar
// valid bits, so no clearing pass is needed.
module peak_hold_gravity_decay #(
  parameter int NUM_BARS  = 64,
  parameter int MAX_FRAME = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [phgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phgd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  phgd_in_if.sink                         in_ch,
  phgd_out_if.source                      out_ch
);
  import phgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  phgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  phgd_dp #(
    .NUM_BARS  (NUM_BARS),
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .magnitude    (in_ch.magnitude),
    .frame_end    (in_ch.frame_end),
    .bar_index    (out_ch.bar_index),
    .peak_level   (out_ch.peak_level),
    .peak_visible (out_ch.peak_visible),
    .last_of_run  (out_ch.last_of_run)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result word is pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken twice in a row");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> !in_ch.ready)
    else $error("run ended without last_of_run");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_of_run) |=> in_ch.ready)
    else $error("block not idle after last word of a run");
`endif

endmodule
`default_nettype wire
